[hdl/qpe_pkg.sv]
// Package for the quoted-printable encoder: character codes, the run type
// and the hex digit lookup. Used by every module of the block.
`default_nettype none
package qpe_pkg;

	localparam logic [7:0] MAX_LINE_RESET = 8'd76;
	localparam int         MAX_RUN        = 6;
	localparam int         RUN_W          = $clog2(MAX_RUN + 1);

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [7:0] PASS_LO_A = 8'd33;
	localparam logic [7:0] PASS_HI_A = 8'd60;
	localparam logic [7:0] PASS_LO_B = 8'd62;
	localparam logic [7:0] PASS_HI_B = 8'd126;

	// one encoded run: bytes in emission order, element 0 first
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [RUN_W-1:0]        len;
	} run_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = 8'h30 + {4'd0, nib};
		end else begin
			d = 8'h37 + {4'd0, nib};
		end
		return d;
	endfunction

endpackage
`default_nettype wire

[hdl/qpe_if.sv]
// Valid/ready channel interfaces for the encoder: raw bytes in, encoded
// bytes out. Depends on nothing.
`default_nettype none
interface qpe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface qpe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

[hdl/qpe_encode.sv]
// Combinational encoder: one raw byte plus the current line count gives the
// whole output run and the next line count. Uses qpe_pkg.
`default_nettype none
module qpe_encode (
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  line_count,
	input  wire logic [7:0]  max_len,
	output qpe_pkg::run_t    run,
	output logic [7:0]       next_count
);
	import qpe_pkg::*;

	logic       pass;
	logic       brk;
	logic [8:0] cnt_pass;
	logic [8:0] cnt_esc;
	logic [7:0] hi;
	logic [7:0] lo;

	always_comb begin
		pass = (data_byte >= PASS_LO_A && data_byte <= PASS_HI_A)
			|| (data_byte >= PASS_LO_B && data_byte <= PASS_HI_B);
		cnt_pass = {1'b0, line_count} + 9'd1;
		cnt_esc  = {1'b0, line_count} + 9'd3;
		hi = hex_digit(data_byte[7:4]);
		lo = hex_digit(data_byte[3:0]);
		run = '0;
		if (pass) begin
			brk = (cnt_pass >= {1'b0, max_len});
			run.bytes[0] = data_byte;
			run.bytes[1] = CH_EQ;
			run.bytes[2] = CH_CR;
			run.bytes[3] = CH_LF;
			run.len = brk ? RUN_W'(4) : RUN_W'(1);
			next_count = brk ? 8'd0 : cnt_pass[7:0];
		end else begin
			brk = (cnt_esc > {1'b0, max_len});
			if (brk) begin
				// soft break ahead of the escape
				run.bytes[0] = CH_EQ;
				run.bytes[1] = CH_CR;
				run.bytes[2] = CH_LF;
				run.bytes[3] = CH_EQ;
				run.bytes[4] = hi;
				run.bytes[5] = lo;
				run.len = RUN_W'(6);
				next_count = 8'd3;
			end else begin
				run.bytes[0] = CH_EQ;
				run.bytes[1] = hi;
				run.bytes[2] = lo;
				run.len = RUN_W'(3);
				next_count = cnt_esc[7:0];
			end
		end
	end

endmodule
`default_nettype wire

[hdl/qpe_run_buf.sv]
// Result register: holds one encoded run and shifts it out a word at a time.
// Uses qpe_pkg.
`default_nettype none
module qpe_run_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire qpe_pkg::run_t run,
	input  wire logic          take,
	output logic               free,
	output logic               valid,
	output logic [7:0]         out_byte,
	output logic               last
);
	import qpe_pkg::*;

	logic [MAX_RUN-1:0][7:0] bytes_q;
	logic [RUN_W-1:0]        rem_q;

	assign valid    = (rem_q != '0);
	assign last     = (rem_q == RUN_W'(1));
	assign out_byte = bytes_q[0];
	// free now, or free once the final word of the run leaves this cycle
	assign free     = !valid || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= run.len;
		end else if (take && valid) begin
			rem_q <= rem_q - RUN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= run.bytes;
		end else if (take && valid) begin
			bytes_q <= {8'd0, bytes_q[MAX_RUN-1:1]};
		end
	end

endmodule
`default_nettype wire

[hdl/quoted_printable_encoder.sv]
// Quoted-printable encoder. Each raw byte on raw yields a run of 1 to 6
// encoded words on enc, the final one flagged by last_of_run. A byte is
// registered on entry, encoded combinationally and moved into a shifting
// result register, so a byte that maps to one word sustains one byte per
// clock while enc is ready; a longer run holds the next byte in the input
// register until its final word is taken. The line limit (reset 76) must be
// written through cfg_we/cfg_wdata while idle; the block does not enforce it.
`default_nettype none
module quoted_printable_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	qpe_in_if.sink          raw,
	qpe_out_if.source       enc,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	import qpe_pkg::*;

	logic [7:0] byte_s1;
	logic       valid_s1;
	logic [7:0] max_len_q;
	logic [7:0] line_count_q;
	logic [7:0] next_count;
	run_t       run;
	logic       free;
	logic       move;
	logic       in_fire;

	assign move      = valid_s1 && free;
	assign raw.ready = !valid_s1 || move;
	assign in_fire   = raw.valid && raw.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= raw.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= MAX_LINE_RESET;
			line_count_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (move) begin
				line_count_q <= next_count;
			end
		end
	end

	qpe_encode u_encode (
		.data_byte  (byte_s1),
		.line_count (line_count_q),
		.max_len    (max_len_q),
		.run        (run),
		.next_count (next_count)
	);

	qpe_run_buf u_run_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (move),
		.run      (run),
		.take     (enc.ready),
		.free     (free),
		.valid    (enc.valid),
		.out_byte (enc.out_byte),
		.last     (enc.last_of_run)
	);

endmodule
`default_nettype wire

[hdl/qpe_checker.sv]
// Port-level checks for the quoted-printable encoder, bound to the top level.
// Uses qpe_pkg for character codes.
`default_nettype none
module qpe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);
	import qpe_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output word changed while stalled");

	// CR only comes from a soft break, never ends a run
	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == CH_CR |-> !out_last)
		else $error("CR flagged as last of run");

	// LF follows CR immediately
	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_byte == CH_CR |=> out_valid && out_byte == CH_LF)
		else $error("CR not followed by LF");

	// LF only ends a break; the word before it is CR, or the same LF held by a stall
	a_lf_after_cr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == CH_LF
		|-> ($past(out_byte) == CH_CR) || ($past(out_byte) == CH_LF))
		else $error("LF without preceding CR");

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (enc.valid),
	.out_ready (enc.ready),
	.out_byte  (enc.out_byte),
	.out_last  (enc.last_of_run)
);
`default_nettype wire
